// ===== hdl/rmez_pkg.sv =====
`default_nettype none
package rmez_pkg;

    localparam int DEF_ANGLE_WIDTH     = 16;
    localparam int DEF_ENTRY_FRAC_BITS = 14;
    localparam int CORDIC_STEPS        = 30;
    localparam int VAL_WIDTH           = 33;
    localparam int PROD_WIDTH          = 2 * VAL_WIDTH;
    localparam int SUM_WIDTH           = PROD_WIDTH + 1;
    localparam int NUM_AXES            = 3;

    localparam logic signed [VAL_WIDTH-1:0] CORDIC_GAIN = 33'sd652032874;

    localparam logic [1:0] QUAD_FIRST  = 2'd0;
    localparam logic [1:0] QUAD_SECOND = 2'd1;
    localparam logic [1:0] QUAD_THIRD  = 2'd2;

    localparam int AXIS_ROLL  = 0;
    localparam int AXIS_PITCH = 1;
    localparam int AXIS_YAW   = 2;

    typedef logic signed [VAL_WIDTH-1:0] t_val;

    typedef struct packed {
        t_val c;
        t_val s;
    } t_trig;

    function automatic t_val atan_turn(input int step);
        t_val res;
        case (step)
            0:  res = 33'sh20000000;
            1:  res = 33'sh12E4051D;
            2:  res = 33'sh09FB385B;
            3:  res = 33'sh051111D4;
            4:  res = 33'sh028B0D43;
            5:  res = 33'sh0145D7E1;
            6:  res = 33'sh00A2F61E;
            7:  res = 33'sh00517C55;
            8:  res = 33'sh0028BE53;
            9:  res = 33'sh00145F2E;
            10: res = 33'sh000A2F98;
            11: res = 33'sh000517CC;
            12: res = 33'sh00028BE6;
            13: res = 33'sh000145F3;
            14: res = 33'sh0000A2F9;
            15: res = 33'sh0000517C;
            16: res = 33'sh000028BE;
            17: res = 33'sh0000145F;
            18: res = 33'sh00000A2F;
            19: res = 33'sh00000517;
            20: res = 33'sh0000028B;
            21: res = 33'sh00000145;
            22: res = 33'sh000000A2;
            23: res = 33'sh00000051;
            24: res = 33'sh00000028;
            25: res = 33'sh00000014;
            26: res = 33'sh0000000A;
            27: res = 33'sh00000005;
            28: res = 33'sh00000002;
            29: res = 33'sh00000001;
            default: res = '0;
        endcase
        return res;
    endfunction

endpackage
`default_nettype wire

// ===== hdl/rmez_cordic.sv =====
`default_nettype none
module rmez_cordic #(
    parameter int ANGLE_WIDTH = rmez_pkg::DEF_ANGLE_WIDTH
) (
    input  wire                          i_clk,
    input  wire                          i_rst_n,
    input  wire                          i_en,
    input  wire                          i_valid,
    input  wire  [ANGLE_WIDTH-1:0]       i_angle [rmez_pkg::NUM_AXES],
    output logic                         o_valid,
    output rmez_pkg::t_trig              o_trig  [rmez_pkg::NUM_AXES]
);
    import rmez_pkg::*;

    logic        r_valid [CORDIC_STEPS+1];
    t_val        r_x     [CORDIC_STEPS+1][NUM_AXES];
    t_val        r_y     [CORDIC_STEPS+1][NUM_AXES];
    t_val        r_z     [CORDIC_STEPS+1][NUM_AXES];
    logic [1:0]  r_quad  [CORDIC_STEPS+1][NUM_AXES];
    logic        r_valid_out;
    t_trig       r_trig  [NUM_AXES];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k <= CORDIC_STEPS; k++) begin
                r_valid[k] <= 1'b0;
            end
            r_valid_out <= 1'b0;
        end else if (i_en) begin
            r_valid[0] <= i_valid;
            for (int k = 0; k < CORDIC_STEPS; k++) begin
                r_valid[k+1] <= r_valid[k];
            end
            r_valid_out <= r_valid[CORDIC_STEPS];
        end
    end

    for (genvar a = 0; a < NUM_AXES; a++) begin : g_axis
        logic [31:0] n_turn;
        assign n_turn = 32'(i_angle[a]) << (32 - ANGLE_WIDTH);

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_x[0][a]    <= CORDIC_GAIN;
                r_y[0][a]    <= '0;
                r_z[0][a]    <= signed'({3'b000, n_turn[29:0]});
                r_quad[0][a] <= n_turn[31:30];
            end
        end

        for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_step
            t_val n_dx;
            t_val n_dy;
            assign n_dx = r_y[i][a] >>> i;
            assign n_dy = r_x[i][a] >>> i;

            always_ff @(posedge i_clk) begin
                if (i_en) begin
                    r_quad[i+1][a] <= r_quad[i][a];
                    if (!r_z[i][a][VAL_WIDTH-1]) begin
                        r_x[i+1][a] <= r_x[i][a] - n_dx;
                        r_y[i+1][a] <= r_y[i][a] + n_dy;
                        r_z[i+1][a] <= r_z[i][a] - atan_turn(i);
                    end else begin
                        r_x[i+1][a] <= r_x[i][a] + n_dx;
                        r_y[i+1][a] <= r_y[i][a] - n_dy;
                        r_z[i+1][a] <= r_z[i][a] + atan_turn(i);
                    end
                end
            end
        end

        t_trig n_trig;
        always_comb begin
            case (r_quad[CORDIC_STEPS][a])
                QUAD_FIRST: begin
                    n_trig.c = r_x[CORDIC_STEPS][a];
                    n_trig.s = r_y[CORDIC_STEPS][a];
                end
                QUAD_SECOND: begin
                    n_trig.c = -r_y[CORDIC_STEPS][a];
                    n_trig.s = r_x[CORDIC_STEPS][a];
                end
                QUAD_THIRD: begin
                    n_trig.c = -r_x[CORDIC_STEPS][a];
                    n_trig.s = -r_y[CORDIC_STEPS][a];
                end
                default: begin
                    n_trig.c = r_y[CORDIC_STEPS][a];
                    n_trig.s = -r_x[CORDIC_STEPS][a];
                end
            endcase
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_trig[a] <= n_trig;
            end
        end

        assign o_trig[a] = r_trig[a];
    end

    assign o_valid = r_valid_out;

endmodule
`default_nettype wire

// ===== hdl/rmez_mat.sv =====
`default_nettype none
module rmez_mat #(
    parameter int ENTRY_FRAC_BITS = rmez_pkg::DEF_ENTRY_FRAC_BITS
) (
    input  wire                          i_clk,
    input  wire                          i_rst_n,
    input  wire                          i_en,
    input  wire                          i_valid,
    input  rmez_pkg::t_trig              i_trig [rmez_pkg::NUM_AXES],
    output logic                         o_valid,
    output logic [ENTRY_FRAC_BITS+1:0]   o_entry [9]
);
    import rmez_pkg::*;

    localparam int SHIFT = 60 - ENTRY_FRAC_BITS;

    logic r_v1, r_v2, r_v3, r_v4;

    t_trig r1_trig [NUM_AXES];
    logic signed [PROD_WIDTH-1:0] r1_sysx, r1_sycx;

    logic signed [PROD_WIDTH-1:0] r2_m [12];
    t_val r2_sy;

    logic signed [SUM_WIDTH-1:0] r3_e [9];

    logic [ENTRY_FRAC_BITS+1:0] r4_e [9];

    logic signed [PROD_WIDTH-1:0] n_sysx_rnd, n_sycx_rnd;
    t_val n_sysx, n_sycx;
    t_val rxc, rxs, ryc, rzc, rzs;

    assign n_sysx_rnd = r1_sysx + (66'sd1 <<< 29);
    assign n_sycx_rnd = r1_sycx + (66'sd1 <<< 29);
    assign n_sysx = signed'(n_sysx_rnd[62:30]);
    assign n_sycx = signed'(n_sycx_rnd[62:30]);
    assign rxc = r1_trig[AXIS_ROLL].c;
    assign rxs = r1_trig[AXIS_ROLL].s;
    assign ryc = r1_trig[AXIS_PITCH].c;
    assign rzc = r1_trig[AXIS_YAW].c;
    assign rzs = r1_trig[AXIS_YAW].s;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
            r_v4 <= 1'b0;
        end else if (i_en) begin
            r_v1 <= i_valid;
            r_v2 <= r_v1;
            r_v3 <= r_v2;
            r_v4 <= r_v3;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r1_trig <= i_trig;
            r1_sysx <= i_trig[AXIS_PITCH].s * i_trig[AXIS_ROLL].s;
            r1_sycx <= i_trig[AXIS_PITCH].s * i_trig[AXIS_ROLL].c;

            r2_sy    <= r1_trig[AXIS_PITCH].s;
            r2_m[0]  <= rzc * ryc;
            r2_m[1]  <= rzc * n_sysx;
            r2_m[2]  <= rzs * rxc;
            r2_m[3]  <= rzc * n_sycx;
            r2_m[4]  <= rzs * rxs;
            r2_m[5]  <= rzs * ryc;
            r2_m[6]  <= rzs * n_sysx;
            r2_m[7]  <= rzc * rxc;
            r2_m[8]  <= rzs * n_sycx;
            r2_m[9]  <= rzc * rxs;
            r2_m[10] <= ryc * rxs;
            r2_m[11] <= ryc * rxc;

            r3_e[0] <= SUM_WIDTH'(r2_m[0]);
            r3_e[1] <= SUM_WIDTH'(r2_m[1]) - SUM_WIDTH'(r2_m[2]);
            r3_e[2] <= SUM_WIDTH'(r2_m[3]) + SUM_WIDTH'(r2_m[4]);
            r3_e[3] <= SUM_WIDTH'(r2_m[5]);
            r3_e[4] <= SUM_WIDTH'(r2_m[6]) + SUM_WIDTH'(r2_m[7]);
            r3_e[5] <= SUM_WIDTH'(r2_m[8]) - SUM_WIDTH'(r2_m[9]);
            r3_e[6] <= -(SUM_WIDTH'(r2_sy) <<< 30);
            r3_e[7] <= SUM_WIDTH'(r2_m[10]);
            r3_e[8] <= SUM_WIDTH'(r2_m[11]);
        end
    end

    for (genvar e = 0; e < 9; e++) begin : g_fin
        logic signed [SUM_WIDTH-1:0] n_rnd, n_shf, n_sat;
        localparam logic signed [SUM_WIDTH-1:0] ONE  = SUM_WIDTH'(1) <<< ENTRY_FRAC_BITS;
        localparam logic signed [SUM_WIDTH-1:0] HALF = SUM_WIDTH'(1) <<< (SHIFT - 1);
        always_comb begin
            n_rnd = r3_e[e] + HALF;
            n_shf = n_rnd >>> SHIFT;
            if (n_shf > ONE) begin
                n_sat = ONE;
            end else if (n_shf < -ONE) begin
                n_sat = -ONE;
            end else begin
                n_sat = n_shf;
            end
        end
        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r4_e[e] <= n_sat[ENTRY_FRAC_BITS+1:0];
            end
        end
        assign o_entry[e] = r4_e[e];
    end

    assign o_valid = r_v4;

endmodule
`default_nettype wire

// ===== hdl/rotation_matrix_from_euler_zyx.sv =====
`default_nettype none
// Euler ZYX to rotation matrix R = Rz(yaw) * Ry(pitch) * Rx(roll). Angles are binary
// angles (2^(ANGLE_WIDTH-1) is pi); entries are signed Q1.ENTRY_FRAC_BITS, saturated to
// +/-1.0. Sine and cosine of all three angles come from a 30-stage CORDIC pipeline, then
// four stages form the products, sums and rounding. One angle triple is taken every
// cycle while o_stall is low. The whole pipeline holds while a result waits under
// stall, so o_stall follows i_stall when the output is full.
module rotation_matrix_from_euler_zyx #(
    parameter int ANGLE_WIDTH     = rmez_pkg::DEF_ANGLE_WIDTH,
    parameter int ENTRY_FRAC_BITS = rmez_pkg::DEF_ENTRY_FRAC_BITS
) (
    input  wire                          i_clk,
    input  wire                          i_rst_n,
    input  wire                          i_valid,
    output logic                         o_stall,
    input  wire  [ANGLE_WIDTH-1:0]       i_roll_angle,
    input  wire  [ANGLE_WIDTH-1:0]       i_pitch_angle,
    input  wire  [ANGLE_WIDTH-1:0]       i_yaw_angle,
    output logic                         o_valid,
    input  wire                          i_stall,
    output logic [ENTRY_FRAC_BITS+1:0]   o_entry_r0c0,
    output logic [ENTRY_FRAC_BITS+1:0]   o_entry_r0c1,
    output logic [ENTRY_FRAC_BITS+1:0]   o_entry_r0c2,
    output logic [ENTRY_FRAC_BITS+1:0]   o_entry_r1c0,
    output logic [ENTRY_FRAC_BITS+1:0]   o_entry_r1c1,
    output logic [ENTRY_FRAC_BITS+1:0]   o_entry_r1c2,
    output logic [ENTRY_FRAC_BITS+1:0]   o_entry_r2c0,
    output logic [ENTRY_FRAC_BITS+1:0]   o_entry_r2c1,
    output logic [ENTRY_FRAC_BITS+1:0]   o_entry_r2c2
);
    import rmez_pkg::*;

    logic                        w_en;
    logic [ANGLE_WIDTH-1:0]      w_angle [NUM_AXES];
    logic                        w_cordic_valid;
    t_trig                       w_trig [NUM_AXES];
    logic [ENTRY_FRAC_BITS+1:0]  w_entry [9];

    assign w_en    = !(o_valid && i_stall);
    assign o_stall = !w_en;

    assign w_angle[AXIS_ROLL]  = i_roll_angle;
    assign w_angle[AXIS_PITCH] = i_pitch_angle;
    assign w_angle[AXIS_YAW]   = i_yaw_angle;

    rmez_cordic #(
        .ANGLE_WIDTH (ANGLE_WIDTH)
    ) u_cordic (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_valid (i_valid),
        .i_angle (w_angle),
        .o_valid (w_cordic_valid),
        .o_trig  (w_trig)
    );

    rmez_mat #(
        .ENTRY_FRAC_BITS (ENTRY_FRAC_BITS)
    ) u_mat (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_valid (w_cordic_valid),
        .i_trig  (w_trig),
        .o_valid (o_valid),
        .o_entry (w_entry)
    );

    assign o_entry_r0c0 = w_entry[0];
    assign o_entry_r0c1 = w_entry[1];
    assign o_entry_r0c2 = w_entry[2];
    assign o_entry_r1c0 = w_entry[3];
    assign o_entry_r1c1 = w_entry[4];
    assign o_entry_r1c2 = w_entry[5];
    assign o_entry_r2c0 = w_entry[6];
    assign o_entry_r2c1 = w_entry[7];
    assign o_entry_r2c2 = w_entry[8];

    localparam logic signed [ENTRY_FRAC_BITS+1:0] ONE_Q =
        (ENTRY_FRAC_BITS+2)'(1) <<< ENTRY_FRAC_BITS;

    a_stall_only_when_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall |-> (o_valid && i_stall))
        else $error("stall raised without a held result");

    a_r0c0_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (signed'(o_entry_r0c0) <= ONE_Q && signed'(o_entry_r0c0) >= -ONE_Q))
        else $error("r0c0 out of range");

    a_r2c2_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (signed'(o_entry_r2c2) <= ONE_Q && signed'(o_entry_r2c2) >= -ONE_Q))
        else $error("r2c2 out of range");

    a_hold_under_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall |=> (o_valid && $stable(o_entry_r1c1)))
        else $error("held result lost");

endmodule
`default_nettype wire

// ===== tb/rmez_matrix_checker.sv =====
module rmez_matrix_checker (
    input  wire         i_clk,
    input  wire         i_rst_n,
    input  wire         i_valid,
    input  wire         i_stall_in,
    input  wire  [15:0] i_roll,
    input  wire  [15:0] i_pitch,
    input  wire  [15:0] i_yaw,
    input  wire         i_out_valid,
    input  wire         i_out_stall,
    input  wire  [15:0] i_e0,
    input  wire  [15:0] i_e1,
    input  wire  [15:0] i_e2,
    input  wire  [15:0] i_e3,
    input  wire  [15:0] i_e4,
    input  wire  [15:0] i_e5,
    input  wire  [15:0] i_e6,
    input  wire  [15:0] i_e7,
    input  wire  [15:0] i_e8,
    output int          o_fail_count,
    output int          o_pending,
    output int          o_matrix_count
);
    typedef logic [8:0][15:0] t_matrix;

    localparam int FRAC = rmez_pkg::DEF_ENTRY_FRAC_BITS;

    t_matrix matrix_q[$];

    function automatic void sin_cos(input logic [15:0] ang, output longint c,
                                    output longint s);
        logic [31:0] a;
        longint x, y, z, dx, dy;
        a = {ang, 16'h0000};
        x = longint'(rmez_pkg::CORDIC_GAIN);
        y = 0;
        z = longint'(a[29:0]);
        for (int i = 0; i < rmez_pkg::CORDIC_STEPS; i++) begin
            dx = y >>> i;
            dy = x >>> i;
            if (z >= 0) begin
                x = x - dx;
                y = y + dy;
                z = z - longint'(rmez_pkg::atan_turn(i));
            end else begin
                x = x + dx;
                y = y - dy;
                z = z + longint'(rmez_pkg::atan_turn(i));
            end
        end
        case (a[31:30])
            rmez_pkg::QUAD_FIRST: begin
                c = x;
                s = y;
            end
            rmez_pkg::QUAD_SECOND: begin
                c = -y;
                s = x;
            end
            rmez_pkg::QUAD_THIRD: begin
                c = -x;
                s = -y;
            end
            default: begin
                c = y;
                s = -x;
            end
        endcase
    endfunction

    function automatic logic [15:0] round_entry(input longint q60);
        longint v, one;
        one = longint'(1) <<< FRAC;
        v = (q60 + (longint'(1) <<< (59 - FRAC))) >>> (60 - FRAC);
        if (v > one) v = one;
        if (v < -one) v = -one;
        return v[15:0];
    endfunction

    function automatic t_matrix zyx_matrix(input logic [15:0] roll, input logic [15:0] pitch,
                                           input logic [15:0] yaw);
        longint cx, sx, cy, sy, cz, sz, sysx, sycx;
        t_matrix m;
        sin_cos(roll, cx, sx);
        sin_cos(pitch, cy, sy);
        sin_cos(yaw, cz, sz);
        sysx = (sy * sx + (longint'(1) <<< 29)) >>> 30;
        sycx = (sy * cx + (longint'(1) <<< 29)) >>> 30;
        m[0] = round_entry(cz * cy);
        m[1] = round_entry(cz * sysx - sz * cx);
        m[2] = round_entry(cz * sycx + sz * sx);
        m[3] = round_entry(sz * cy);
        m[4] = round_entry(sz * sysx + cz * cx);
        m[5] = round_entry(sz * sycx - cz * sx);
        m[6] = round_entry(-(sy <<< 30));
        m[7] = round_entry(cy * sx);
        m[8] = round_entry(cy * cx);
        return m;
    endfunction

    task automatic report_mismatch(input string msg);
        $display("MISMATCH at %0t: %s", $realtime, msg);
        o_fail_count++;
    endtask

    initial begin
        o_fail_count = 0;
        o_matrix_count = 0;
    end

    assign o_pending = matrix_q.size();

    always @(posedge i_clk) begin
        t_matrix got, want;
        got = {i_e8, i_e7, i_e6, i_e5, i_e4, i_e3, i_e2, i_e1, i_e0};
        if (i_rst_n) begin
            if (i_valid && !i_stall_in) begin
                matrix_q = {matrix_q, zyx_matrix(i_roll, i_pitch, i_yaw)};
            end
            if (i_out_valid && !i_out_stall) begin
                o_matrix_count++;
                if (matrix_q.size() == 0) begin
                    report_mismatch("result transfer with nothing expected");
                end else begin
                    want = matrix_q.pop_front();
                    for (int k = 0; k < 9; k++) begin
                        if (got[k] !== want[k]) begin
                            report_mismatch($sformatf("entry r%0dc%0d got %h want %h",
                                                      k / 3, k % 3, got[k], want[k]));
                        end
                    end
                end
            end
        end
    end
endmodule

// ===== tb/tb_rotation_matrix_from_euler_zyx.sv =====
module tb_rotation_matrix_from_euler_zyx;
    localparam int NUM_RANDOM = 1200;
    localparam int WATCHDOG_LIMIT = 3000;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_valid;
    logic        i_stall;
    logic [15:0] i_roll_angle;
    logic [15:0] i_pitch_angle;
    logic [15:0] i_yaw_angle;
    logic        o_stall;
    logic        o_valid;
    logic [15:0] o_entry_r0c0, o_entry_r0c1, o_entry_r0c2;
    logic [15:0] o_entry_r1c0, o_entry_r1c1, o_entry_r1c2;
    logic [15:0] o_entry_r2c0, o_entry_r2c1, o_entry_r2c2;

    int fail_count;
    int pending;
    int matrix_count;
    int sent_count;
    int quiet_cycles;
    bit busy_stretch;

    rotation_matrix_from_euler_zyx u_top (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_valid(i_valid), .o_stall(o_stall),
        .i_roll_angle(i_roll_angle), .i_pitch_angle(i_pitch_angle),
        .i_yaw_angle(i_yaw_angle), .o_valid(o_valid), .i_stall(i_stall),
        .o_entry_r0c0(o_entry_r0c0), .o_entry_r0c1(o_entry_r0c1),
        .o_entry_r0c2(o_entry_r0c2), .o_entry_r1c0(o_entry_r1c0),
        .o_entry_r1c1(o_entry_r1c1), .o_entry_r1c2(o_entry_r1c2),
        .o_entry_r2c0(o_entry_r2c0), .o_entry_r2c1(o_entry_r2c1),
        .o_entry_r2c2(o_entry_r2c2)
    );

    rmez_matrix_checker u_checker (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_valid(i_valid), .i_stall_in(o_stall),
        .i_roll(i_roll_angle), .i_pitch(i_pitch_angle), .i_yaw(i_yaw_angle),
        .i_out_valid(o_valid), .i_out_stall(i_stall),
        .i_e0(o_entry_r0c0), .i_e1(o_entry_r0c1), .i_e2(o_entry_r0c2),
        .i_e3(o_entry_r1c0), .i_e4(o_entry_r1c1), .i_e5(o_entry_r1c2),
        .i_e6(o_entry_r2c0), .i_e7(o_entry_r2c1), .i_e8(o_entry_r2c2),
        .o_fail_count(fail_count), .o_pending(pending), .o_matrix_count(matrix_count)
    );

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    function automatic bit want_idle();
        return !busy_stretch && ($urandom_range(99) < 29);
    endfunction

    always @(posedge i_clk) begin
        i_stall <= i_rst_n && want_idle();
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (i_valid && !o_stall) || (o_valid && !i_stall)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("watchdog: no transfer for %0d cycles", WATCHDOG_LIMIT);
            $display("rotation_matrix_from_euler_zyx test failed");
            $finish;
        end
    end

    task automatic send_angles(input logic [15:0] roll, input logic [15:0] pitch,
                               input logic [15:0] yaw);
        bit taken;
        while (want_idle()) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_roll_angle <= roll;
        i_pitch_angle <= pitch;
        i_yaw_angle <= yaw;
        do begin
            @(negedge i_clk);
            taken = !o_stall;
            @(posedge i_clk);
        end while (!taken);
        sent_count++;
    endtask

    function automatic logic [15:0] pick_angle();
        logic [15:0] corners[8] = '{16'h0000, 16'h4000, 16'h8000, 16'hC000,
                                    16'h2000, 16'h7FFF, 16'hFFFF, 16'h0001};
        case ($urandom_range(3))
            0: return corners[$urandom_range(7)] + 16'($urandom_range(4)) - 16'd2;
            default: return 16'($urandom());
        endcase
    endfunction

    initial begin
        static logic [15:0] dir[20] = '{16'h0000, 16'h7FFF, 16'h8000, 16'hFFFF, 16'h0001,
                                        16'h4000, 16'hC000, 16'h3FFF, 16'h4001, 16'hBFFF,
                                        16'h2000, 16'hE000, 16'h6000, 16'hA000, 16'h5555,
                                        16'hAAAA, 16'h1234, 16'h8001, 16'h7FFE, 16'hC001};
        i_rst_n = 1'b0;
        i_valid = 1'b0;
        i_stall = 1'b0;
        i_roll_angle = '0;
        i_pitch_angle = '0;
        i_yaw_angle = '0;
        quiet_cycles = 0;
        sent_count = 0;
        busy_stretch = 1'b0;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        for (int k = 0; k < 20; k++) begin
            send_angles(dir[k], dir[(k + 7) % 20], dir[(k + 13) % 20]);
        end
        send_angles(16'h4000, 16'h4000, 16'h0000);
        send_angles(16'h0000, 16'hC000, 16'h4000);
        for (int n = 0; n < NUM_RANDOM; n++) begin
            busy_stretch = (n >= 500 && n < 700);
            send_angles(pick_angle(), pick_angle(), pick_angle());
        end
        busy_stretch = 1'b0;
        i_valid <= 1'b0;
        while (pending != 0) @(posedge i_clk);
        repeat (40) @(posedge i_clk);
        $display("sent %0d angle triples, checked %0d matrices across quadrant edges",
                 sent_count, matrix_count);
        if (fail_count == 0) begin
            $display("rotation_matrix_from_euler_zyx test passed");
        end else begin
            $display("rotation_matrix_from_euler_zyx test failed");
        end
        $finish;
    end
endmodule

// ===== files.f =====
hdl/rmez_pkg.sv
hdl/rmez_cordic.sv
hdl/rmez_mat.sv
hdl/rotation_matrix_from_euler_zyx.sv
tb/rmez_matrix_checker.sv
tb/tb_rotation_matrix_from_euler_zyx.sv
